[hw/rtl/sobel_gradient_magnitude_core_defines.svh]
// assertion macros for the sobel gradient magnitude core
`ifndef SOBEL_GRADIENT_MAGNITUDE_CORE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_CORE_DEFINES_SVH

// same-cycle implication
`define SGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sgm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types and constants of the sobel gradient magnitude core.
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int CHANNEL_BITS = 8;
    localparam int MAX_HEIGHT   = 4096;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = 12;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int PIX_W        = 3 * CHANNEL_BITS;
    localparam int GRAD_W       = CHANNEL_BITS + 3;
    localparam int SQ_W         = 2 * GRAD_W - 2;
    localparam int SUM_W        = SQ_W + 1;
    localparam int ROOT_W       = GRAD_W;
    localparam int TRIAL_W      = SUM_W + 2;
    localparam int BIT_W        = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_ROUND,
        ST_OUTPUT
    } sgm_state_t;

    typedef struct packed {
        logic             load;
        logic             shift;
        logic             grad;
        logic             square;
        logic             root_step;
        logic             round;
        logic [1:0]       sel;
        logic [BIT_W-1:0] bit_idx;
        logic             is_last;
    } sgm_cmd_t;

    typedef struct packed {
        logic [3:0] emit_mask;
    } sgm_status_t;

endpackage

[hw/rtl/sgm_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm interfaces
// Pixel, magnitude and configuration request channels.
// ----------------------------------------------------------------------------
interface sgm_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pix_b;
    logic [7:0] pix_g;
    logic [7:0] pix_r;

    modport source (output valid, pix_b, pix_g, pix_r, input ready);
    modport sink (input valid, pix_b, pix_g, pix_r, output ready);
endinterface

interface sgm_mag_if;
    logic        valid;
    logic        ready;
    logic [7:0]  mag_b;
    logic [7:0]  mag_g;
    logic [7:0]  mag_r;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        run_last;

    modport source (output valid, mag_b, mag_g, mag_r, out_row, out_col, run_last,
                    input ready);
    modport sink (input valid, mag_b, mag_g, mag_r, out_row, out_col, run_last,
                  output ready);
endinterface

interface sgm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/sobel_gradient_magnitude_core.sv]
`timescale 1ns / 1ps
// sequence: a pixel is taken, and the window moves in the next cycle; each result
// then passes gradient, square, 11 root steps, round and output, plus stall.
// a new pixel is taken only once every result of the last one is out, set by the
// bit-serial square root shared by the results of one pixel.
// reset: asynchronous active low; counters and window clear, registers go to
// 640 x 480, line stores hold old data and are overwritten before use.
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_core
// 3x3 sobel edge magnitude on a raster bgr pixel stream.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_core (
    input  logic      clk,
    input  logic      rst_n,
    sgm_pix_if.sink   pix,
    sgm_mag_if.source mag,
    sgm_cfg_if.sink   cfg
);
    import sgm_pkg::*;

    sgm_cmd_t    cmd;
    sgm_status_t status;

    assign cfg.ready = 1'b1;

    sgm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_valid (mag.valid),
        .out_ready (mag.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sgm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .pix_b     (pix.pix_b),
        .pix_g     (pix.pix_g),
        .pix_r     (pix.pix_r),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .mag_b     (mag.mag_b),
        .mag_g     (mag.mag_g),
        .mag_r     (mag.mag_r),
        .out_row   (mag.out_row),
        .out_col   (mag.out_col),
        .run_last  (mag.run_last)
    );

endmodule

[hw/rtl/sgm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_datapath
// Line stores, window, counters, gradient, squares and shared square root.
// ----------------------------------------------------------------------------
module sgm_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sgm_pkg::sgm_cmd_t                    cmd,
    output sgm_pkg::sgm_status_t                 status,
    input  logic [sgm_pkg::CHANNEL_BITS-1:0]     pix_b,
    input  logic [sgm_pkg::CHANNEL_BITS-1:0]     pix_g,
    input  logic [sgm_pkg::CHANNEL_BITS-1:0]     pix_r,
    input  logic                                 cfg_we,
    input  logic [sgm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sgm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [sgm_pkg::CHANNEL_BITS-1:0]     mag_b,
    output logic [sgm_pkg::CHANNEL_BITS-1:0]     mag_g,
    output logic [sgm_pkg::CHANNEL_BITS-1:0]     mag_r,
    output logic [sgm_pkg::ROW_W-1:0]            out_row,
    output logic [sgm_pkg::COL_W-1:0]            out_col,
    output logic                                 run_last
);
    import sgm_pkg::*;

    logic [PIX_W-1:0]        upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0]        lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0]        up_rd_reg;
    logic [PIX_W-1:0]        lo_rd_reg;
    logic [PIX_W-1:0]        px_reg;
    logic [PIX_W-1:0]        win_reg [3][3];

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]        col_reg;
    logic [ROW_W-1:0]        row_reg;
    logic [COL_W-1:0]        cur_col_reg;
    logic [ROW_W-1:0]        cur_row_reg;
    logic [3:0]              mask_reg;

    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;
    logic                    col_last;
    logic                    row_last;

    logic signed [GRAD_W-1:0] gx_reg [3];
    logic signed [GRAD_W-1:0] gy_reg [3];
    logic [SUM_W-1:0]         s_reg  [3];
    logic [ROOT_W-1:0]        q_reg  [3];
    logic [SUM_W-1:0]         sq_reg [3];

    logic [CHANNEL_BITS-1:0]  mag_reg [3];
    logic [ROW_W-1:0]         out_row_reg;
    logic [COL_W-1:0]         out_col_reg;
    logic                     run_last_reg;

    logic [1:0]               rsel [3];
    logic [1:0]               csel [3];

    // effective frame size
    always_comb
    begin
        if (width_reg < WIDTH_REG_W'(2))
            w_eff = WIDTH_REG_W'(2);
        else if (width_reg > WIDTH_REG_W'(MAX_WIDTH))
            w_eff = WIDTH_REG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < HEIGHT_REG_W'(2))
            h_eff = HEIGHT_REG_W'(2);
        else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT))
            h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign col_last = ({1'b0, col_reg} == w_eff - WIDTH_REG_W'(1));
    assign row_last = ({1'b0, row_reg} == h_eff - HEIGHT_REG_W'(1));

    // line stores with registered read at the current column
    always_ff @(posedge clk)
    begin
        up_rd_reg <= upper_mem[col_reg];
        lo_rd_reg <= lower_mem[col_reg];
        if (cmd.shift)
        begin
            upper_mem[col_reg] <= lo_rd_reg;
            lower_mem[col_reg] <= px_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            px_reg <= {pix_r, pix_g, pix_b};
    end

    // window, counters, frame size registers and emit flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win_reg[i][j] <= '0;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            mask_reg    <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT))
            begin
                if (cfg_index == CFG_IMAGE_WIDTH)
                    width_reg <= cfg_data[WIDTH_REG_W-1:0];
                else
                    height_reg <= cfg_data;
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.shift)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= up_rd_reg;
                win_reg[1][2] <= lo_rd_reg;
                win_reg[2][2] <= px_reg;
                cur_col_reg   <= col_reg;
                cur_row_reg   <= row_reg;
                mask_reg[0]   <= (row_reg != '0) && (col_reg != '0);
                mask_reg[1]   <= (row_reg != '0) && col_last;
                mask_reg[2]   <= (row_reg != '0) && row_last && (col_reg != '0);
                mask_reg[3]   <= (row_reg != '0) && row_last && col_last;
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    assign status.emit_mask = mask_reg;

    // window taps for the selected output position
    always_comb
    begin
        if (cmd.sel[1])
        begin
            rsel[0] = 2'd1;
            rsel[1] = 2'd2;
            rsel[2] = 2'd2;
        end
        else
        begin
            rsel[0] = (cur_row_reg == ROW_W'(1)) ? 2'd1 : 2'd0;
            rsel[1] = 2'd1;
            rsel[2] = 2'd2;
        end
        if (cmd.sel[0])
        begin
            csel[0] = 2'd1;
            csel[1] = 2'd2;
            csel[2] = 2'd2;
        end
        else
        begin
            csel[0] = (cur_col_reg == COL_W'(1)) ? 2'd1 : 2'd0;
            csel[1] = 2'd1;
            csel[2] = 2'd2;
        end
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        logic signed [GRAD_W-1:0] p [3][3];
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [SQ_W-1:0]          gx_sq;
        logic [SQ_W-1:0]          gy_sq;
        logic [TRIAL_W-1:0]       trial;
        logic [ROOT_W:0]          q_round;
        logic [SUM_W-1:0]         rem;

        always_comb
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    p[i][j] = $signed({3'b000,
                        win_reg[rsel[i]][csel[j]][ch*CHANNEL_BITS +: CHANNEL_BITS]});
            gx = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
            gy = (p[0][0] + (p[0][1] <<< 1) + p[0][2])
               - (p[2][0] + (p[2][1] <<< 1) + p[2][2]);
        end

        logic signed [2*GRAD_W-1:0] gx_prod;
        logic signed [2*GRAD_W-1:0] gy_prod;
        assign gx_prod = gx_reg[ch] * gx_reg[ch];
        assign gy_prod = gy_reg[ch] * gy_reg[ch];
        assign gx_sq   = gx_prod[SQ_W-1:0];
        assign gy_sq   = gy_prod[SQ_W-1:0];

        // trial square: (q + 2^b)^2 = q^2 + q*2^(b+1) + 2^(2b)
        assign trial = TRIAL_W'(sq_reg[ch])
                     + (TRIAL_W'(q_reg[ch]) << (cmd.bit_idx + BIT_W'(1)))
                     + (TRIAL_W'(1) << {cmd.bit_idx, 1'b0});
        assign rem     = s_reg[ch] - sq_reg[ch];
        assign q_round = (rem > SUM_W'(q_reg[ch])) ? {1'b0, q_reg[ch]} + (ROOT_W+1)'(1)
                                                   : {1'b0, q_reg[ch]};

        always_ff @(posedge clk)
        begin
            if (cmd.grad)
            begin
                gx_reg[ch] <= gx;
                gy_reg[ch] <= gy;
            end
            if (cmd.square)
            begin
                s_reg[ch]  <= SUM_W'(gx_sq) + SUM_W'(gy_sq);
                q_reg[ch]  <= '0;
                sq_reg[ch] <= '0;
            end
            else if (cmd.root_step && (trial <= TRIAL_W'(s_reg[ch])))
            begin
                q_reg[ch]  <= q_reg[ch] | (ROOT_W'(1) << cmd.bit_idx);
                sq_reg[ch] <= trial[SUM_W-1:0];
            end
            if (cmd.round)
                mag_reg[ch] <= (q_round > (ROOT_W+1)'(255)) ? CHANNEL_BITS'(255)
                                                            : q_round[CHANNEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            out_row_reg  <= cmd.sel[1] ? cur_row_reg : cur_row_reg - ROW_W'(1);
            out_col_reg  <= cmd.sel[0] ? cur_col_reg : cur_col_reg - COL_W'(1);
            run_last_reg <= cmd.is_last;
        end
    end

    assign mag_b    = mag_reg[0];
    assign mag_g    = mag_reg[1];
    assign mag_r    = mag_reg[2];
    assign out_row  = out_row_reg;
    assign out_col  = out_col_reg;
    assign run_last = run_last_reg;

endmodule

[hw/rtl/sgm_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_controller
// Sequences one pixel: window update, then each pending result in turn.
// ----------------------------------------------------------------------------
module sgm_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sgm_pkg::sgm_status_t status,
    output sgm_pkg::sgm_cmd_t    cmd
);
    import sgm_pkg::*;

    sgm_state_t       state_reg;
    sgm_state_t       state_next;
    logic [1:0]       sel_reg;
    logic [1:0]       sel_next;
    logic [BIT_W-1:0] bit_reg;
    logic [BIT_W-1:0] bit_next;
    logic [1:0]       first_sel;
    logic [1:0]       after_sel;
    logic             more;
    logic [3:0]       above;

    always_comb
    begin
        first_sel = 2'd3;
        for (int k = 3; k >= 0; k--)
            if (status.emit_mask[k])
                first_sel = 2'(k);
    end

    // results still pending after the current one
    assign above = status.emit_mask & ~((4'd2 << sel_reg) - 4'd1);
    assign more  = (above != 4'd0);

    always_comb
    begin
        after_sel = sel_reg;
        for (int k = 3; k >= 0; k--)
            if (above[k])
                after_sel = 2'(k);
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_SHIFT;
            ST_SHIFT:
                state_next = ST_GRAD;
            ST_GRAD:
            begin
                // mask is valid from here on
                if (status.emit_mask == 4'd0)
                    state_next = ST_IDLE;
                else if (status.emit_mask[sel_reg])
                    state_next = ST_SQUARE;
                else
                begin
                    sel_next   = first_sel;
                    state_next = ST_GRAD;
                end
            end
            ST_SQUARE:
            begin
                bit_next   = BIT_W'(ROOT_W - 1);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                    state_next = ST_ROUND;
            end
            ST_ROUND:
                state_next = ST_OUTPUT;
            ST_OUTPUT:
                if (out_ready)
                begin
                    if (more)
                    begin
                        sel_next   = after_sel;
                        state_next = ST_GRAD;
                    end
                    else
                    begin
                        sel_next   = 2'd0;
                        state_next = ST_IDLE;
                    end
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.sel       = sel_reg;
        cmd.bit_idx   = bit_reg;
        cmd.is_last   = !more;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SHIFT:  cmd.shift     = 1'b1;
            ST_GRAD:   cmd.grad      = 1'b1;
            ST_SQUARE: cmd.square    = 1'b1;
            ST_ROOT:   cmd.root_step = 1'b1;
            ST_ROUND:  cmd.round     = 1'b1;
            ST_OUTPUT: out_valid     = 1'b1;
            default:   cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 2'd0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

[hw/rtl/sgm_checker.sv]
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_core_defines.svh"
// ----------------------------------------------------------------------------
// sgm_checker
// Port-level checks of the sobel gradient magnitude core.
// ----------------------------------------------------------------------------
module sgm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  mag_b,
    input logic [10:0] out_col,
    input logic        cfg_ready
);

    `SGM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(mag_b) && $stable(out_col), "result dropped or changed while stalled")
    `SGM_ASSERT_NOW(a_no_take_while_out, clk, rst_n, out_valid, !in_ready, "pixel request taken while result pending")
    `SGM_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid, "core not busy after pixel request")
    `SGM_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready, "config request not ready")

endmodule

bind sobel_gradient_magnitude_core sgm_checker u_sgm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (mag.valid),
    .out_ready (mag.ready),
    .mag_b     (mag.mag_b),
    .out_col   (mag.out_col),
    .cfg_ready (cfg.ready)
);
